@@ hdl/clnws_pkg.sv @@
// shared types, register map and constants of the character lcd nibble write sequencer
`default_nettype none

package clnws_pkg;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_POWER_UP    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE      = 2'd2;

  // timing register widths and reset values
  localparam int unsigned POWER_UP_W    = 24;
  localparam int unsigned ENABLE_HIGH_W = 8;
  localparam int unsigned SETTLE_W      = 16;
  localparam int unsigned WAIT_W        = 24;

  localparam logic [POWER_UP_W-1:0]    POWER_UP_RESET    = 24'd13333333;
  localparam logic [ENABLE_HIGH_W-1:0] ENABLE_HIGH_RESET = 8'd10;
  localparam logic [SETTLE_W-1:0]      SETTLE_RESET      = 16'd50000;

  localparam logic [WAIT_W-1:0] WAIT_ONE = 24'd1;

  // request opcodes
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_CMD    = 3'd1,
    OP_CHAR   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_CURSOR = 3'd4
  } op_t;

  // lcd command bytes
  localparam logic [7:0] BYTE_DISPLAY_ON = 8'h0F;
  localparam logic [7:0] BYTE_CLEAR      = 8'h01;
  localparam logic [7:0] ROW1_BASE       = 8'h80;
  localparam logic [7:0] ROW2_BASE       = 8'hC0;
  localparam logic [1:0] ROW_FIRST       = 2'd1;

  // init sequence bookkeeping
  localparam logic [2:0] INIT_BYTE_STEP = 3'd4;
  localparam logic [2:0] INIT_DONE      = 3'd5;
  localparam logic [2:0] INIT_LAST_NIB  = 3'd3;

  // sequencer phases
  typedef enum logic [3:0] {
    PH_POWER  = 4'b0001,
    PH_ENHIGH = 4'b0010,
    PH_SETTLE = 4'b0100,
    PH_IDLE   = 4'b1000
  } phase_t;

  // classified request handed from front to back
  typedef struct packed {
    logic       start;
    logic       rs;
    logic [7:0] data;
  } req_t;

  // queue geometry
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // power-on nibble sequence 3, 3, 3, 2
  function automatic logic [3:0] init_nibble(input logic [1:0] idx);
    logic [3:0] nib;
    nib = (idx == 2'd3) ? 4'h2 : 4'h3;
    return nib;
  endfunction

  // phase length n shown on n beats, zero treated as one
  function automatic logic [WAIT_W-1:0] len_minus_one(input logic [WAIT_W-1:0] n);
    logic [WAIT_W-1:0] r;
    r = (n == '0) ? '0 : n - WAIT_ONE;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/char_lcd_nibble_write_sequencer.sv @@
// top level of the character lcd 4-bit write sequencer
`default_nettype none

// Drives a character LCD controller over a 4-bit write-only bus. Every input
// beat is one tick of time and yields exactly one result beat carrying the pin
// levels after that tick, the busy flag and whether the beat's request was taken.
// After reset enable is held high for power_up_ticks, then nibbles 3, 3, 3, 2 and
// the command 0x0F are sent; later requests (command, character, clear, cursor)
// go out as two nibbles, high first, each enable_high_ticks high and settle_ticks
// low. Requests while busy are refused. One beat is taken every clock cycle
// while the queue is not full; the sequencer advances one tick per cycle
// while a beat is queued and the output is not stalled. A two-entry queue
// between the request decoder and the sequencer lets input and output stall
// independently. The user must write timing registers only when no beats are
// in flight; the block does not enforce this. cfg_ready is always high.
module char_lcd_nibble_write_sequencer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         op,
  input  logic [7:0]                         byte_value,
  input  logic [1:0]                         row,
  input  logic [5:0]                         column,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               rs_pin,
  output logic                               rw_pin,
  output logic                               en_pin,
  output logic [3:0]                         data_nibble,
  output logic                               busy_res,
  output logic                               accepted,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [clnws_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [clnws_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import clnws_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_nonempty;
  req_t q_entry;
  req_t q_head;

  // request decode
  clnws_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .byte_value (byte_value),
    .row        (row),
    .column     (column),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  // decoupling queue
  clnws_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .nonempty   (q_nonempty),
    .head       (q_head),
    .pop        (q_pop)
  );

  // pin sequencer and result register
  clnws_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_nonempty  (q_nonempty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .rs_pin      (rs_pin),
    .rw_pin      (rw_pin),
    .en_pin      (en_pin),
    .data_nibble (data_nibble),
    .busy_res    (busy_res),
    .accepted    (accepted)
  );

endmodule

`default_nettype wire

@@ hdl/clnws_front.sv @@
// front end: takes request beats and turns them into byte transfers for the queue
`default_nettype none

module clnws_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        op,
  input  logic [7:0]        byte_value,
  input  logic [1:0]        row,
  input  logic [5:0]        column,
  input  logic              q_full,
  output logic              q_push,
  output clnws_pkg::req_t   q_entry
);
  import clnws_pkg::*;

  logic [7:0] cursor_addr;

  // hold off the source while the queue is full
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // cursor address is row base plus column, at most 0xFF, so it never wraps
  assign cursor_addr = ((row == ROW_FIRST) ? ROW1_BASE : ROW2_BASE) + {2'b00, column};

  // classify the opcode into a byte and register select
  always_comb begin
    q_entry.start = 1'b0;
    q_entry.rs    = 1'b0;
    q_entry.data  = '0;
    unique case (op)
      OP_CMD: begin
        q_entry.start = 1'b1;
        q_entry.data  = byte_value;
      end
      OP_CHAR: begin
        q_entry.start = 1'b1;
        q_entry.rs    = 1'b1;
        q_entry.data  = byte_value;
      end
      OP_CLEAR: begin
        q_entry.start = 1'b1;
        q_entry.data  = BYTE_CLEAR;
      end
      OP_CURSOR: begin
        q_entry.start = 1'b1;
        q_entry.data  = cursor_addr;
      end
      default: begin
        // plain tick and unused codes only advance time
        q_entry.start = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/clnws_queue.sv @@
// two-entry queue between request decode and the pin sequencer
`default_nettype none

module clnws_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  clnws_pkg::req_t push_entry,
  output logic            full,
  output logic            nonempty,
  output clnws_pkg::req_t head,
  input  logic            pop
);
  import clnws_pkg::*;

  localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);
  localparam logic [QUEUE_CNT_W-1:0] CNT_ONE    = QUEUE_CNT_W'(1);
  localparam logic [QUEUE_PTR_W-1:0] PTR_ONE    = QUEUE_PTR_W'(1);

  req_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full     = (count == QUEUE_FULL);
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_ONE;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_ONE;
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_ONE;
        2'b01:   count <= count - CNT_ONE;
        default: count <= count;
      endcase
    end
  end

  // neither side may overrun or underrun the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("queue pop while empty");

endmodule

`default_nettype wire

@@ hdl/clnws_back.sv @@
// back end: timing registers, power-up and nibble sequencer, result register
`default_nettype none

module clnws_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_nonempty,
  input  clnws_pkg::req_t                     q_head,
  output logic                                q_pop,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [clnws_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [clnws_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                rs_pin,
  output logic                                rw_pin,
  output logic                                en_pin,
  output logic [3:0]                          data_nibble,
  output logic                                busy_res,
  output logic                                accepted
);
  import clnws_pkg::*;

  // timing registers
  logic [POWER_UP_W-1:0]    power_up_ticks;
  logic [ENABLE_HIGH_W-1:0] enable_high_ticks;
  logic [SETTLE_W-1:0]      settle_ticks;

  // sequencer state
  phase_t            phase, phase_next;
  logic [WAIT_W-1:0] wait_count, wait_count_next;
  logic [2:0]        init_step, init_step_next;
  logic [7:0]        pending_byte, pending_byte_next;
  logic              pending_rs, pending_rs_next;
  logic              low_half_next, low_half_next_next;
  logic              rs_level, rs_level_next;
  logic              en_level, en_level_next;
  logic [3:0]        nib_level, nib_level_next;
  logic              acc_next;

  logic       start_nib;
  logic [3:0] start_nib_val;
  logic       start_nib_rs;
  logic [2:0] init_step_inc;
  logic       cfg_write;

  // one queued beat advances the sequencer by one tick
  assign q_pop     = q_nonempty && (!out_valid || !out_stall);
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign rw_pin    = 1'b0;

  assign init_step_inc = init_step + 3'd1;

  // next state for one tick
  always_comb begin
    phase_next         = phase;
    wait_count_next    = wait_count;
    init_step_next     = init_step;
    pending_byte_next  = pending_byte;
    pending_rs_next    = pending_rs;
    low_half_next_next = low_half_next;
    rs_level_next      = rs_level;
    en_level_next      = en_level;
    nib_level_next     = nib_level;
    acc_next           = 1'b0;
    start_nib          = 1'b0;
    start_nib_val      = '0;
    start_nib_rs       = 1'b0;

    if (phase == PH_IDLE) begin
      // idle: a byte request starts its high nibble
      if (q_head.start) begin
        acc_next           = 1'b1;
        pending_byte_next  = q_head.data;
        pending_rs_next    = q_head.rs;
        low_half_next_next = 1'b1;
        start_nib          = 1'b1;
        start_nib_val      = q_head.data[7:4];
        start_nib_rs       = q_head.rs;
      end
    end else if (wait_count == '0) begin
      // current phase ends on this tick
      unique case (phase)
        PH_POWER: begin
          init_step_next = '0;
          start_nib      = 1'b1;
          start_nib_val  = init_nibble(2'd0);
        end
        PH_ENHIGH: begin
          en_level_next   = 1'b0;
          phase_next      = PH_SETTLE;
          wait_count_next = len_minus_one(WAIT_W'(settle_ticks));
        end
        PH_SETTLE: begin
          if (init_step < INIT_BYTE_STEP) begin
            init_step_next = init_step_inc;
            start_nib      = 1'b1;
            if (init_step != INIT_LAST_NIB) begin
              start_nib_val = init_nibble(init_step_inc[1:0]);
            end else begin
              // init nibbles done, send display-on command
              pending_byte_next  = BYTE_DISPLAY_ON;
              pending_rs_next    = 1'b0;
              low_half_next_next = 1'b1;
              start_nib_val      = BYTE_DISPLAY_ON[7:4];
            end
          end else if (low_half_next) begin
            low_half_next_next = 1'b0;
            start_nib          = 1'b1;
            start_nib_val      = pending_byte[3:0];
            start_nib_rs       = pending_rs;
          end else begin
            init_step_next  = INIT_DONE;
            phase_next      = PH_IDLE;
            wait_count_next = '0;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end else begin
      wait_count_next = wait_count - WAIT_ONE;
    end

    // raise enable with the new nibble on the data lines
    if (start_nib) begin
      rs_level_next   = start_nib_rs;
      en_level_next   = 1'b1;
      nib_level_next  = start_nib_val;
      phase_next      = PH_ENHIGH;
      wait_count_next = len_minus_one(WAIT_W'(enable_high_ticks));
    end
  end

  // timing register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      power_up_ticks    <= POWER_UP_RESET;
      enable_high_ticks <= ENABLE_HIGH_RESET;
      settle_ticks      <= SETTLE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_POWER_UP:    power_up_ticks    <= cfg_data[POWER_UP_W-1:0];
        REG_ENABLE_HIGH: enable_high_ticks <= cfg_data[ENABLE_HIGH_W-1:0];
        REG_SETTLE:      settle_ticks      <= cfg_data[SETTLE_W-1:0];
        default:         power_up_ticks    <= power_up_ticks;
      endcase
    end
  end

  // sequencer registers; a power-up length write in PH_POWER restarts the wait
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_POWER;
      wait_count    <= WAIT_W'(POWER_UP_RESET);
      init_step     <= '0;
      pending_byte  <= '0;
      pending_rs    <= 1'b0;
      low_half_next <= 1'b0;
      rs_level      <= 1'b0;
      en_level      <= 1'b1;
      nib_level     <= '0;
    end else begin
      if (q_pop) begin
        phase         <= phase_next;
        init_step     <= init_step_next;
        pending_byte  <= pending_byte_next;
        pending_rs    <= pending_rs_next;
        low_half_next <= low_half_next_next;
        rs_level      <= rs_level_next;
        en_level      <= en_level_next;
        nib_level     <= nib_level_next;
      end
      if (cfg_write && (cfg_index == REG_POWER_UP) && (phase == PH_POWER)) begin
        wait_count <= WAIT_W'(cfg_data[POWER_UP_W-1:0]);
      end else if (q_pop) begin
        wait_count <= wait_count_next;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rs_pin      <= rs_level_next;
      en_pin      <= en_level_next;
      data_nibble <= nib_level_next;
      busy_res    <= (phase_next != PH_IDLE);
      accepted    <= acc_next;
    end
  end

  // enable is never left high once the sequencer is idle
  a_idle_en_low: assert property (@(posedge clk) disable iff (rst)
    en_level |-> (phase != PH_IDLE))
    else $error("enable high while idle");

  // a taken request always shows its first strobe and busy
  a_accept_strobe: assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted) |-> (en_pin && busy_res))
    else $error("accepted beat without enable strobe");

  // idle is reached only after the init sequence finished
  a_idle_after_init: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (init_step == INIT_DONE))
    else $error("idle before init done");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// self-checking testbench for the character lcd nibble write sequencer
`default_nettype none

module testbench;
  import clnws_pkg::*;

  // run length and limits
  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned RAND_PHASES     = 6;
  localparam int unsigned BEATS_PER_PHASE = 104;
  localparam int unsigned LONG_TAIL       = 270;
  localparam int unsigned MAX_GAP         = 11;

  // codes with no name in the package
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // power-on nibble values
  localparam logic [3:0] INIT_NIB      = 4'h3;
  localparam logic [3:0] INIT_NIB_LAST = 4'h2;

  // one result beat as seen on the pins
  typedef struct packed {
    logic       rs;
    logic       rw;
    logic       en;
    logic [3:0] nib;
    logic       busy;
    logic       acc;
  } pin_beat_t;

  localparam pin_beat_t NO_PIN    = '0;
  localparam pin_beat_t PWR_HOLD  = '{rs: 1'b0, rw: 1'b0, en: 1'b1, nib: 4'h0,
                                      busy: 1'b1, acc: 1'b0};
  localparam pin_beat_t FIRST_NIB = '{rs: 1'b0, rw: 1'b0, en: 1'b1, nib: INIT_NIB,
                                      busy: 1'b1, acc: 1'b0};

  // directed stimulus table
  typedef enum logic {ROW_BEAT, ROW_WRITE} plan_kind_t;

  typedef struct packed {
    plan_kind_t                 kind;
    logic [CFG_INDEX_W-1:0]     reg_idx;
    logic [CFG_DATA_W-1:0]      reg_val;
    logic [2:0]                 op;
    logic [7:0]                 byte_value;
    logic [1:0]                 row;
    logic [5:0]                 column;
    logic [7:0]                 reps;
    logic                       typed;
    pin_beat_t                  want;
  } plan_row_t;

  localparam int unsigned PLAN_ROWS = 32;

  localparam plan_row_t PLAN [0:PLAN_ROWS-1] = '{
    // power-up wait with reset timing, request refused
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_TICK,      8'h00, 2'd0, 6'd0,  8'd1,  1'b1, PWR_HOLD},
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_CMD,       8'hFF, 2'd3, 6'd63, 8'd1,  1'b1, PWR_HOLD},
    // zero strobe and settle lengths act as one
    '{ROW_WRITE, REG_ENABLE_HIGH, 24'h000000, OP_TICK,      8'h00, 2'd0, 6'd0,  8'd0,  1'b0, NO_PIN},
    '{ROW_WRITE, REG_SETTLE,      24'h000000, OP_TICK,      8'h00, 2'd0, 6'd0,  8'd0,  1'b0, NO_PIN},
    // longest power-up restarts the wait
    '{ROW_WRITE, REG_POWER_UP,    24'hFFFFFF, OP_TICK,      8'h00, 2'd0, 6'd0,  8'd0,  1'b0, NO_PIN},
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_CURSOR,    8'hFF, 2'd1, 6'd63, 8'd1,  1'b1, PWR_HOLD},
    // zero power-up: next beat already shows the first init nibble
    '{ROW_WRITE, REG_POWER_UP,    24'h000000, OP_TICK,      8'h00, 2'd0, 6'd0,  8'd0,  1'b0, NO_PIN},
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_TICK,      8'h00, 2'd0, 6'd0,  8'd1,  1'b1, FIRST_NIB},
    // request during init, then run init out
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_CHAR,      8'h00, 2'd0, 6'd0,  8'd1,  1'b0, NO_PIN},
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_TICK,      8'h00, 2'd0, 6'd0,  8'd10, 1'b0, NO_PIN},
    // request on the beat that ends init is refused
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_CMD,       8'hA5, 2'd0, 6'd0,  8'd1,  1'b0, NO_PIN},
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_CMD,       8'h5A, 2'd0, 6'd0,  8'd1,  1'b0, NO_PIN},
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_TICK,      8'h00, 2'd0, 6'd0,  8'd4,  1'b0, NO_PIN},
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_CHAR,      8'hFF, 2'd0, 6'd0,  8'd1,  1'b0, NO_PIN},
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_TICK,      8'h00, 2'd0, 6'd0,  8'd3,  1'b0, NO_PIN},
    // request on the beat that ends a transfer is refused
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_CHAR,      8'h00, 2'd0, 6'd0,  8'd1,  1'b0, NO_PIN},
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_CHAR,      8'h00, 2'd0, 6'd0,  8'd1,  1'b0, NO_PIN},
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_TICK,      8'h00, 2'd0, 6'd0,  8'd4,  1'b0, NO_PIN},
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_CLEAR,     8'h00, 2'd0, 6'd0,  8'd1,  1'b0, NO_PIN},
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_TICK,      8'h00, 2'd0, 6'd0,  8'd4,  1'b0, NO_PIN},
    // cursor on the first row, highest column
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_CURSOR,    8'h00, 2'd1, 6'd63, 8'd1,  1'b0, NO_PIN},
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_TICK,      8'h00, 2'd0, 6'd0,  8'd4,  1'b0, NO_PIN},
    // every other row value selects the second row
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_CURSOR,    8'h00, 2'd0, 6'd0,  8'd1,  1'b0, NO_PIN},
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_TICK,      8'h00, 2'd0, 6'd0,  8'd4,  1'b0, NO_PIN},
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_CURSOR,    8'h00, 2'd2, 6'd21, 8'd1,  1'b0, NO_PIN},
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_TICK,      8'h00, 2'd0, 6'd0,  8'd4,  1'b0, NO_PIN},
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_CURSOR,    8'hFF, 2'd3, 6'd63, 8'd1,  1'b0, NO_PIN},
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_TICK,      8'h00, 2'd0, 6'd0,  8'd4,  1'b0, NO_PIN},
    // unknown ops behave as ticks
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_UNUSED_HI, 8'hFF, 2'd3, 6'd63, 8'd1,  1'b0, NO_PIN},
    '{ROW_BEAT,  REG_POWER_UP,    24'h000000, OP_UNUSED_LO, 8'h00, 2'd0, 6'd0,  8'd1,  1'b0, NO_PIN},
    // unused index ignored, power-up written outside its wait only stored
    '{ROW_WRITE, REG_UNUSED,      24'hFFFFFF, OP_TICK,      8'h00, 2'd0, 6'd0,  8'd0,  1'b0, NO_PIN},
    '{ROW_WRITE, REG_POWER_UP,    24'h000001, OP_TICK,      8'h00, 2'd0, 6'd0,  8'd0,  1'b0, NO_PIN}
  };

  // clock, reset and block ports
  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   in_valid   = 1'b0;
  logic                   in_stall;
  logic [2:0]             op         = '0;
  logic [7:0]             byte_value = '0;
  logic [1:0]             row        = '0;
  logic [5:0]             column     = '0;
  logic                   out_valid;
  logic                   out_stall  = 1'b0;
  logic                   rs_pin;
  logic                   rw_pin;
  logic                   en_pin;
  logic [3:0]             data_nibble;
  logic                   busy_res;
  logic                   accepted;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  char_lcd_nibble_write_sequencer dut (
    .clk, .rst, .in_valid, .in_stall, .op, .byte_value, .row, .column,
    .out_valid, .out_stall, .rs_pin, .rw_pin, .en_pin, .data_nibble, .busy_res, .accepted,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sequencer state as predicted by the bench
  phase_t               lcd_phase;
  logic [WAIT_W-1:0]    lcd_wait;
  logic [2:0]           lcd_init_step;
  logic [7:0]           lcd_byte;
  logic                 lcd_byte_rs;
  logic                 lcd_low_next;
  logic                 lcd_rs;
  logic                 lcd_en;
  logic [3:0]           lcd_nib;
  logic [ENABLE_HIGH_W-1:0] lcd_enable_high;
  logic [SETTLE_W-1:0]  lcd_settle;

  // expected pin beats, oldest first
  pin_beat_t pending_pins_q [$];

  // run bookkeeping
  logic        gaps_on     = 1'b1;
  int unsigned hold_left   = 0;
  int unsigned cycle_count = 0;
  int unsigned beats_sent  = 0;
  int unsigned taken_count = 0;
  int unsigned writes_done = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches  = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("mismatch on result beat %0d: %s got %0h expected %0h",
             results_seen, what, got, want);
  endtask

  // phase length n lasts n beats, zero counts as one
  function automatic logic [WAIT_W-1:0] span_less_one(input logic [WAIT_W-1:0] n);
    return (n == '0) ? '0 : n - 24'd1;
  endfunction

  task automatic raise_nibble(input logic [3:0] nib, input logic rs_lvl);
    lcd_rs    = rs_lvl;
    lcd_en    = 1'b1;
    lcd_nib   = nib;
    lcd_phase = PH_ENHIGH;
    lcd_wait  = span_less_one({16'd0, lcd_enable_high});
  endtask

  task automatic begin_byte(input logic [7:0] b, input logic rs_lvl);
    lcd_byte     = b;
    lcd_byte_rs  = rs_lvl;
    lcd_low_next = 1'b1;
    raise_nibble(b[7:4], rs_lvl);
  endtask

  // advance one tick and work out the pin beat it yields
  task automatic next_pin_levels(input logic [2:0] r_op, input logic [7:0] r_byte,
                                 input logic [1:0] r_row, input logic [5:0] r_col,
                                 output pin_beat_t r);
    logic took;
    took = 1'b0;
    if (lcd_phase == PH_IDLE) begin
      took = 1'b1;
      case (r_op)
        OP_CMD:    begin_byte(r_byte, 1'b0);
        OP_CHAR:   begin_byte(r_byte, 1'b1);
        OP_CLEAR:  begin_byte(BYTE_CLEAR, 1'b0);
        OP_CURSOR: begin_byte(((r_row == ROW_FIRST) ? ROW1_BASE : ROW2_BASE) + {2'b00, r_col},
                              1'b0);
        default:   took = 1'b0;
      endcase
    end else if (lcd_wait != '0) begin
      lcd_wait = lcd_wait - 24'd1;
    end else if (lcd_phase == PH_POWER) begin
      lcd_init_step = '0;
      raise_nibble(INIT_NIB, 1'b0);
    end else if (lcd_phase == PH_ENHIGH) begin
      lcd_en    = 1'b0;
      lcd_phase = PH_SETTLE;
      lcd_wait  = span_less_one({8'd0, lcd_settle});
    end else if (lcd_init_step < INIT_BYTE_STEP) begin
      // init nibbles, then the display-on byte
      lcd_init_step = lcd_init_step + 3'd1;
      if (lcd_init_step < INIT_BYTE_STEP)
        raise_nibble((lcd_init_step == INIT_LAST_NIB) ? INIT_NIB_LAST : INIT_NIB, 1'b0);
      else
        begin_byte(BYTE_DISPLAY_ON, 1'b0);
    end else if (lcd_low_next) begin
      lcd_low_next = 1'b0;
      raise_nibble(lcd_byte[3:0], lcd_byte_rs);
    end else begin
      lcd_init_step = INIT_DONE;
      lcd_phase     = PH_IDLE;
      lcd_wait      = '0;
    end
    r = '{rs: lcd_rs, rw: 1'b0, en: lcd_en, nib: lcd_nib,
          busy: (lcd_phase != PH_IDLE), acc: took};
  endtask

  // send one input beat, entered and left at a falling edge
  task automatic send_beat(input logic [2:0] b_op, input logic [7:0] b_byte,
                           input logic [1:0] b_row, input logic [5:0] b_col,
                           input logic typed, input pin_beat_t want);
    int unsigned gap;
    pin_beat_t   predicted;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    op         <= b_op;
    byte_value <= b_byte;
    row        <= b_row;
    column     <= b_col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    next_pin_levels(b_op, b_byte, b_row, b_col, predicted);
    pending_pins_q.push_back(typed ? want : predicted);
    taken_count += predicted.acc;
    beats_sent++;
    @(negedge clk);
  endtask

  // stop sending and wait until every expected beat is back
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_pins_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // timing register write, with no beats in flight
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      // power-up only restarts the wait while it runs
      REG_POWER_UP:    if (lcd_phase == PH_POWER) lcd_wait = val;
      REG_ENABLE_HIGH: lcd_enable_high = val[ENABLE_HIGH_W-1:0];
      REG_SETTLE:      lcd_settle = val[SETTLE_W-1:0];
      default: ;
    endcase
    writes_done++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // result checking, receiver stalls and the cycle limit
  always @(posedge clk) begin : watch_results
    pin_beat_t got;
    pin_beat_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL char_lcd_nibble_write_sequencer");
      $finish;
    end else if (!rst && out_valid && !out_stall) begin
      got = '{rs: rs_pin, rw: rw_pin, en: en_pin, nib: data_nibble,
              busy: busy_res, acc: accepted};
      if (pending_pins_q.size() == 0) begin
        report_mismatch("beat with none pending", 1, 0);
      end else begin
        want = pending_pins_q.pop_front();
        if (got.rs !== want.rs)     report_mismatch("rs_pin", got.rs, want.rs);
        if (got.rw !== want.rw)     report_mismatch("rw_pin", got.rw, want.rw);
        if (got.en !== want.en)     report_mismatch("en_pin", got.en, want.en);
        if (got.nib !== want.nib)   report_mismatch("data_nibble", got.nib, want.nib);
        if (got.busy !== want.busy) report_mismatch("busy_res", got.busy, want.busy);
        if (got.acc !== want.acc)   report_mismatch("accepted", got.acc, want.acc);
      end
      results_seen++;
      hold_left = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    end else if (hold_left != 0) begin
      hold_left--;
    end
  end

  always @(negedge clk) begin
    out_stall <= (hold_left != 0);
  end

  initial begin : stimulus
    int unsigned pick;
    logic [2:0]  rand_op;

    // predictor reset state
    lcd_phase       = PH_POWER;
    lcd_wait        = POWER_UP_RESET;
    lcd_init_step   = '0;
    lcd_byte        = '0;
    lcd_byte_rs     = 1'b0;
    lcd_low_next    = 1'b0;
    lcd_rs          = 1'b0;
    lcd_en          = 1'b1;
    lcd_nib         = '0;
    lcd_enable_high = ENABLE_HIGH_RESET;
    lcd_settle      = SETTLE_RESET;

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        quiesce();
        write_reg(PLAN[i].reg_idx, PLAN[i].reg_val);
      end else begin
        repeat (PLAN[i].reps)
          send_beat(PLAN[i].op, PLAN[i].byte_value, PLAN[i].row, PLAN[i].column,
                    PLAN[i].typed, PLAN[i].want);
      end
    end

    // random phases with short timings, some with no idling at all
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      quiesce();
      gaps_on = ((ph % 3) != 1);
      write_reg(REG_ENABLE_HIGH, {16'($urandom), 8'($urandom_range(0, 4))});
      write_reg(REG_SETTLE, {8'($urandom), 16'($urandom_range(0, 6))});
      write_reg(REG_POWER_UP, 24'($urandom));
      repeat (BEATS_PER_PHASE) begin
        pick = $urandom_range(0, 9);
        if (pick < 5)
          rand_op = OP_TICK;
        else if (pick < 9)
          rand_op = 3'($urandom_range(OP_CMD, OP_CURSOR));
        else
          rand_op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        send_beat(rand_op, 8'($urandom), 2'($urandom), 6'($urandom), 1'b0, NO_PIN);
      end
    end

    // one character with the longest strobe and settle, past the strobe into settle
    quiesce();
    gaps_on = 1'b0;
    write_reg(REG_ENABLE_HIGH, 24'h0000FF);
    write_reg(REG_SETTLE, 24'h00FFFF);
    send_beat(OP_CHAR, 8'($urandom), 2'($urandom), 6'($urandom), 1'b0, NO_PIN);
    repeat (LONG_TAIL)
      send_beat(3'($urandom), 8'($urandom), 2'($urandom), 6'($urandom), 1'b0, NO_PIN);

    quiesce();
    repeat (8) @(negedge clk);

    $display("covered %0d beats from power-up through init, %0d requests taken", beats_sent,
             taken_count);
    $display("%0d register writes, zero and longest timings, %0d mismatches", writes_done,
             mismatches);
    if (mismatches == 0)
      $display("PASS char_lcd_nibble_write_sequencer");
    else
      $display("FAIL char_lcd_nibble_write_sequencer");
    $finish;
  end

endmodule

`default_nettype wire
